/* sv/b64e_pkg.sv */
package b64e_pkg;

	localparam int QUEUE_DEPTH = 2;

	localparam logic [6:0] PAD_CODE = 7'h3D;

	// One accepted byte turns into a job of one to four characters.
	typedef struct packed {
		logic [3:0][6:0] chars;
		logic [1:0]      n_m1;
		logic            msg_last;
	} job_t;

	// Standard alphabet: A-Z, a-z, 0-9, '+', '/'.
	function automatic logic [6:0] sextet_char(input logic [5:0] v);
		logic [6:0] r;
		if (v < 6'd26) begin
			r = 7'(v) + 7'd65;
		end else if (v < 6'd52) begin
			r = 7'(v) + 7'd71;
		end else if (v < 6'd62) begin
			r = 7'(v) - 7'd4;
		end else if (v == 6'd62) begin
			r = 7'h2B;
		end else begin
			r = 7'h2F;
		end
		return r;
	endfunction

endpackage

/* sv/b64e_byte_if.sv */
interface b64e_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source(output valid, output data_byte, output last_byte, input ready);
	modport sink(input valid, input data_byte, input last_byte, output ready);
endinterface

/* sv/b64e_char_if.sv */
interface b64e_char_if;
	logic       valid;
	logic       ready;
	logic [6:0] char_code;
	logic       last_char;

	modport source(output valid, output char_code, output last_char, input ready);
	modport sink(input valid, input char_code, input last_char, output ready);
endinterface

/* sv/b64e_front.sv */
module b64e_front (
	input  logic                clk,
	input  logic                arst_n,
	b64e_byte_if.sink           in_ch,
	output logic                push_valid,
	output b64e_pkg::job_t      push_job,
	input  logic                push_ready
);

	localparam logic [1:0] POS_0 = 2'd0;
	localparam logic [1:0] POS_1 = 2'd1;
	localparam logic [1:0] POS_2 = 2'd2;

	logic [1:0] pos_q;
	logic [3:0] left_q;
	logic       accept;
	logic [7:0] b;

	assign in_ch.ready = push_ready;
	assign push_valid  = in_ch.valid;
	assign accept      = in_ch.valid && push_ready;
	assign b           = in_ch.data_byte;

	always_comb begin
		push_job          = '0;
		push_job.msg_last = in_ch.last_byte;
		unique case (pos_q)
			POS_1: begin
				push_job.chars[0] = b64e_pkg::sextet_char({left_q[1:0], b[7:4]});
				if (in_ch.last_byte) begin
					push_job.chars[1] = b64e_pkg::sextet_char({b[3:0], 2'b00});
					push_job.chars[2] = b64e_pkg::PAD_CODE;
					push_job.n_m1     = 2'd2;
				end
			end
			POS_2: begin
				push_job.chars[0] = b64e_pkg::sextet_char({left_q, b[7:6]});
				push_job.chars[1] = b64e_pkg::sextet_char(b[5:0]);
				push_job.n_m1     = 2'd1;
			end
			default: begin
				// The unused position code behaves as the start of a group.
				push_job.chars[0] = b64e_pkg::sextet_char(b[7:2]);
				if (in_ch.last_byte) begin
					push_job.chars[1] = b64e_pkg::sextet_char({b[1:0], 4'b0000});
					push_job.chars[2] = b64e_pkg::PAD_CODE;
					push_job.chars[3] = b64e_pkg::PAD_CODE;
					push_job.n_m1     = 2'd3;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= POS_0;
			left_q <= '0;
		end else if (accept) begin
			if (in_ch.last_byte || pos_q == POS_2) begin
				pos_q  <= POS_0;
				left_q <= '0;
			end else if (pos_q == POS_1) begin
				pos_q  <= POS_2;
				left_q <= b[3:0];
			end else begin
				pos_q  <= POS_1;
				left_q <= {2'b00, b[1:0]};
			end
		end
	end

	a_last_resets: assert property (@(posedge clk) disable iff (!arst_n)
		accept && in_ch.last_byte |=> pos_q == POS_0 && left_q == 4'd0)
		else $error("group state not cleared after last byte");

	a_pos2_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && pos_q == POS_2 |=> pos_q == POS_0)
		else $error("group did not close after third byte");

endmodule

/* sv/b64e_queue.sv */
module b64e_queue #(
	parameter int Depth = b64e_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	input  b64e_pkg::job_t  push_job,
	output logic            push_ready,
	output logic            pop_valid,
	output b64e_pkg::job_t  pop_job,
	input  logic            pop
);

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	b64e_pkg::job_t   mem_q [Depth];
	logic [PtrW-1:0]  wr_ptr_q;
	logic [PtrW-1:0]  rd_ptr_q;
	logic [CntW-1:0]  count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = count_q != CntW'(Depth);
	assign pop_valid  = count_q != '0;
	assign pop_job    = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
		return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(Depth))
		else $error("queue count beyond depth");

	a_no_empty_pop: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("pop requested from empty queue");

endmodule

/* sv/b64e_back.sv */
module b64e_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            pop_valid,
	input  b64e_pkg::job_t  pop_job,
	output logic            pop,
	b64e_char_if.source     out_ch
);

	b64e_pkg::job_t cur_q;
	logic           cur_valid_q;
	logic [1:0]     idx_q;
	logic           out_valid_q;
	logic [6:0]     out_char_q;
	logic           out_last_q;
	logic           adv;
	logic           cur_done;

	assign adv      = !out_valid_q || out_ch.ready;
	assign cur_done = cur_valid_q && adv && (idx_q == cur_q.n_m1);
	assign pop      = pop_valid && (!cur_valid_q || cur_done);

	assign out_ch.valid     = out_valid_q;
	assign out_ch.char_code = out_char_q;
	assign out_ch.last_char = out_last_q;

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= pop_job;
		end
		if (adv && cur_valid_q) begin
			out_char_q <= cur_q.chars[idx_q];
			out_last_q <= cur_q.msg_last && (idx_q == cur_q.n_m1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				out_valid_q <= cur_valid_q;
			end
			if (pop) begin
				cur_valid_q <= 1'b1;
				idx_q       <= '0;
			end else if (cur_done) begin
				cur_valid_q <= 1'b0;
				idx_q       <= '0;
			end else if (adv && cur_valid_q) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cur_valid_q |-> idx_q <= cur_q.n_m1)
		else $error("character index past end of job");

	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		adv && cur_valid_q |=> out_valid_q)
		else $error("character lost on the way to the output register");

endmodule

/* sv/base64_stream_encoder_core.sv */
// Base64 encoder core: one raw byte in, one to four ASCII characters out.
// Each character passes the job queue, current-job register and output register.
// Throughput: one character per cycle while out_ch.ready is held, set by the output
// serializer; a byte yields 1 or 2 characters mid-message, 2 to 4 on the last.
// Reset (arst_n low, asynchronous) clears the group position, leftover bits,
// the job queue and the output register.
module base64_stream_encoder_core #(
	parameter int QueueDepth = b64e_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	b64e_byte_if.sink   in_ch,
	b64e_char_if.source out_ch
);

	logic           push_valid;
	logic           push_ready;
	b64e_pkg::job_t push_job;
	logic           pop_valid;
	logic           pop;
	b64e_pkg::job_t pop_job;

	b64e_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.push_valid (push_valid),
		.push_job   (push_job),
		.push_ready (push_ready)
	);

	b64e_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_job   (push_job),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_job    (pop_job),
		.pop        (pop)
	);

	b64e_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_job   (pop_job),
		.pop       (pop),
		.out_ch    (out_ch)
	);

endmodule

/* test/tb.sv */
`timescale 1ns / 100ps

module tb;

	localparam int RANDOM_BYTES   = 140;
	localparam int TAIL_CYCLES    = 16;
	localparam int CYCLE_LIMIT    = 400000;

	typedef enum logic [1:0] {GRP_FIRST, GRP_SECOND, GRP_THIRD} grp_pos_t;

	typedef struct packed {
		logic [6:0] code;
		logic       last;
	} enc_char_t;

	// Tracks the position in the 3-byte group and the carried bits, and keeps the
	// characters that the accepted bytes must still produce, oldest first.
	class b64_scoreboard;
		enc_char_t expected_chars[$];
		grp_pos_t  pos;
		logic [3:0] carry;
		string     alphabet;
		int        n_bytes;
		int        n_chars;
		int        n_msgs;
		int        errors;

		function new();
			alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
			pos = GRP_FIRST;
			carry = '0;
			n_bytes = 0;
			n_chars = 0;
			n_msgs = 0;
			errors = 0;
		endfunction

		function logic [6:0] to_char(logic [5:0] v);
			return 7'(alphabet.getc(int'(v)));
		endfunction

		function void add_char(logic [6:0] code, logic last);
			enc_char_t c;
			c.code = code;
			c.last = last;
			expected_chars = {expected_chars, c};
		endfunction

		function int pending();
			return expected_chars.size();
		endfunction

		function void note_byte(logic [7:0] b, logic fin);
			n_bytes++;
			case (pos)
				GRP_SECOND: begin
					add_char(to_char({carry[1:0], b[7:4]}), 1'b0);
					if (fin) begin
						add_char(to_char({b[3:0], 2'b00}), 1'b0);
						add_char(b64e_pkg::PAD_CODE, 1'b1);
					end else begin
						carry = b[3:0];
						pos = GRP_THIRD;
					end
				end
				GRP_THIRD: begin
					add_char(to_char({carry, b[7:6]}), 1'b0);
					add_char(to_char(b[5:0]), fin);
					carry = '0;
					pos = GRP_FIRST;
				end
				default: begin
					// Carried bits are meaningless at the start of a group.
					add_char(to_char(b[7:2]), 1'b0);
					if (fin) begin
						add_char(to_char({b[1:0], 4'b0000}), 1'b0);
						add_char(b64e_pkg::PAD_CODE, 1'b0);
						add_char(b64e_pkg::PAD_CODE, 1'b1);
					end else begin
						carry = {2'b00, b[1:0]};
						pos = GRP_SECOND;
					end
				end
			endcase
			if (fin) begin
				pos = GRP_FIRST;
				carry = '0;
				n_msgs++;
			end
		endfunction

		function void check_char(logic [6:0] code, logic last);
			enc_char_t exp_c;
			n_chars++;
			if (expected_chars.size() == 0) begin
				$error("unexpected character: char_code=%h last_char=%b", code, last);
				errors++;
			end else begin
				exp_c = expected_chars.pop_front();
				if (code !== exp_c.code) begin
					$error("char_code mismatch: expected %h, actual %h", exp_c.code, code);
					errors++;
				end
				if (last !== exp_c.last) begin
					$error("last_char mismatch: expected %b, actual %b", exp_c.last, last);
					errors++;
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	int   cycle_count = 0;
	bit   send_calm = 1'b0;
	bit   recv_calm = 1'b0;

	b64_scoreboard enc_board = new();

	b64e_byte_if byte_ch();
	b64e_char_if char_ch();

	base64_stream_encoder_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (byte_ch.sink),
		.out_ch (char_ch.source)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("tb: failure");
		$finish;
	end

	// Now and then a side switches between idling at random and running flat out.
	function automatic int draw_wait(inout bit calm);
		if ($urandom_range(0, 15) == 0) begin
			calm = !calm;
		end
		return calm ? 0 : int'($urandom_range(0, 15));
	endfunction

	task automatic send_byte(input logic [7:0] d, input logic fin);
		int gap;
		gap = draw_wait(send_calm);
		if (gap > 0) begin
			byte_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_ch.valid <= 1'b1;
		byte_ch.data_byte <= d;
		byte_ch.last_byte <= fin;
		do @(posedge clk); while (!byte_ch.ready);
		enc_board.note_byte(d, fin);
	endtask

	task automatic send_message(input logic [7:0] msg[$]);
		foreach (msg[i]) begin
			send_byte(msg[i], i == msg.size() - 1);
		end
	endtask

	task automatic wait_drained();
		byte_ch.valid <= 1'b0;
		do @(posedge clk); while (enc_board.pending() != 0);
	endtask

	task automatic receive_chars();
		int stall;
		forever begin
			stall = draw_wait(recv_calm);
			if (stall > 0) begin
				char_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			char_ch.ready <= 1'b1;
			do @(posedge clk); while (!char_ch.valid);
			enc_board.check_char(char_ch.char_code, char_ch.last_char);
		end
	endtask

	initial begin
		wait (arst_n === 1'b1);
		@(posedge clk);
		receive_chars();
	end

	initial begin
		logic [7:0] msg[$];
		int len;
		int sent;
		arst_n <= 1'b0;
		byte_ch.valid <= 1'b0;
		byte_ch.data_byte <= '0;
		byte_ch.last_byte <= 1'b0;
		char_ch.ready <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Messages of one to six bytes end at every group position; the
		// group FB FF BF produces the two symbol characters.
		send_message({8'hFF});
		send_message({8'h00, 8'hFF});
		send_message({8'hFB, 8'hFF, 8'hBF});
		send_message({8'h00, 8'h00, 8'h00, 8'h01});
		send_message({8'h4D, 8'h61, 8'h6E, 8'h61, 8'h62});
		send_message({8'h4D, 8'h61, 8'h6E, 8'h12, 8'h34, 8'h56});
		wait_drained();

		sent = 0;
		while (sent < RANDOM_BYTES) begin
			len = ($urandom_range(0, 9) == 0) ?
				$urandom_range(13, 40) : $urandom_range(1, 12);
			msg.delete();
			repeat (len) msg = {msg, 8'($urandom)};
			send_message(msg);
			sent += len;
			if ($urandom_range(0, 5) == 0) begin
				wait_drained();
			end
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Covered %0d messages, %0d bytes and %0d characters",
			enc_board.n_msgs, enc_board.n_bytes, enc_board.n_chars);
		$display("with random gaps on both sides and full drains between bursts.");
		if (enc_board.errors == 0 && enc_board.pending() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

/* base64_stream_encoder_core.f */
sv/b64e_pkg.sv
sv/b64e_byte_if.sv
sv/b64e_char_if.sv
sv/b64e_front.sv
sv/b64e_queue.sv
sv/b64e_back.sv
sv/base64_stream_encoder_core.sv
test/tb.sv
